/* sv/url_enc_pkg.sv */
// url_enc_pkg: shared types, character codes and helper functions
// for the url percent encoder; no dependencies
package url_enc_pkg;

  localparam int MAX_OUT = 7;
  localparam int CNT_W   = 3;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef logic [7:0] char_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // one expanded word group produced by a single input word
  typedef struct packed {
    cnt_t                     count;
    logic                     last;
    logic [MAX_OUT-1:0][7:0]  chars;
  } expansion_t;

  function automatic logic is_digit(input char_t c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input char_t c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_hex(input char_t c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic is_plain(input char_t c);
    return is_alpha(c) || is_digit(c) || (c == CH_DASH) || (c == CH_UNDER) ||
           (c == CH_DOT) || (c == CH_TILDE);
  endfunction

  function automatic char_t hex_upper(input logic [3:0] v);
    char_t r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'h0, v};
    end else begin
      r = 8'h37 + {4'h0, v};
    end
    return r;
  endfunction

endpackage

/* sv/url_enc_if.sv */
// url_enc_if: valid/ready channel interfaces for input bytes and encoded words
// depends on url_enc_pkg
interface url_enc_in_if
  import url_enc_pkg::*;
;
  logic  valid;
  logic  ready;
  char_t in_char;
  logic  string_last;

  modport source (output valid, output in_char, output string_last, input ready);
  modport sink   (input valid, input in_char, input string_last, output ready);
endinterface

interface url_enc_out_if
  import url_enc_pkg::*;
;
  logic  valid;
  logic  ready;
  char_t out_char;
  logic  run_last;
  logic  string_end;

  modport source (output valid, output out_char, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input out_char, input run_last, input string_end,
                  output ready);
endinterface

/* sv/url_percent_encoder_core.sv */
// url_percent_encoder_core: top level of the streaming url percent encoder
// depends on url_enc_pkg, url_enc_if, url_enc_expand, url_enc_emit
//
// in_ch carries one raw string byte per word with string_last on the final
// byte; out_ch carries the encoded string one character per word, with
// run_last on the final character caused by an input word and string_end on
// the final character of the string. both channels use valid/ready.
// an accepted byte is expanded combinationally into up to seven characters that
// are loaded into a shift buffer; the first one then moves to the output
// register and the rest follow one per cycle while out_ch does not stall.
// the single output register limits the rate: a byte keeps in_ch waiting while
// the characters it produces (1 or 3 typically, up to 7 with a flushed hold)
// move out, and a byte that only extends a percent hold produces none.
// the next byte is taken in the cycle the last character of the previous one
// moves to the output register.
// when out_ch stalls the output register holds its word and in_ch.ready drops
// once the buffer still has characters waiting. reset clears the hold state,
// the buffer count and the output valid; no clearing pass is needed.
module url_percent_encoder_core
  import url_enc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  url_enc_in_if.sink        in_ch,
  url_enc_out_if.source     out_ch
);

  expansion_t exp;
  logic       take;
  logic       accept;

  assign in_ch.ready = take;
  assign accept      = in_ch.valid && take;

  url_enc_expand u_expand (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_char     (in_ch.in_char),
    .string_last (in_ch.string_last),
    .exp         (exp)
  );

  url_enc_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .take       (take),
    .exp        (exp),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_char   (out_ch.out_char),
    .run_last   (out_ch.run_last),
    .string_end (out_ch.string_end)
  );

endmodule

/* sv/url_enc_expand.sv */
// url_enc_expand: per-byte encoding into up to seven characters, holds the
// pending percent state; depends on url_enc_pkg
module url_enc_expand
  import url_enc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  char_t      in_char,
  input  logic       string_last,
  output expansion_t exp
);

  typedef enum logic [2:0] {
    PEND_NONE  = 3'b001,
    PEND_PCT   = 3'b010,
    PEND_DIGIT = 3'b100
  } pend_t;

  pend_t                   pend_r, pend_nxt;
  char_t                   held_r, held_nxt;
  logic [MAX_OUT-1:0][7:0] seq;
  cnt_t                    n;
  logic                    do_enc;
  logic                    c_hex;

  always_comb begin
    seq      = '0;
    n        = '0;
    pend_nxt = PEND_NONE;
    held_nxt = '0;
    do_enc   = 1'b0;
    c_hex    = is_hex(in_char);

    case (pend_r)
      PEND_PCT: begin
        if (c_hex) begin
          pend_nxt = PEND_DIGIT;
          held_nxt = in_char;
        end else begin
          seq[n] = CH_PCT;  n = n + 3'd1;
          seq[n] = CH_TWO;  n = n + 3'd1;
          seq[n] = CH_FIVE; n = n + 3'd1;
          do_enc = 1'b1;
        end
      end
      PEND_DIGIT: begin
        if (c_hex) begin
          seq[n] = CH_PCT;  n = n + 3'd1;
          seq[n] = held_r;  n = n + 3'd1;
          seq[n] = in_char; n = n + 3'd1;
        end else begin
          seq[n] = CH_PCT;  n = n + 3'd1;
          seq[n] = CH_TWO;  n = n + 3'd1;
          seq[n] = CH_FIVE; n = n + 3'd1;
          seq[n] = held_r;  n = n + 3'd1;
          do_enc = 1'b1;
        end
      end
      default: begin
        do_enc = 1'b1;
      end
    endcase

    if (do_enc) begin
      if (in_char == CH_PCT) begin
        pend_nxt = PEND_PCT;
      end else if (is_plain(in_char)) begin
        seq[n] = in_char; n = n + 3'd1;
      end else if (in_char == CH_SPACE) begin
        seq[n] = CH_PLUS; n = n + 3'd1;
      end else begin
        seq[n] = CH_PCT;                 n = n + 3'd1;
        seq[n] = hex_upper(in_char[7:4]); n = n + 3'd1;
        seq[n] = hex_upper(in_char[3:0]); n = n + 3'd1;
      end
    end

    // flush whatever is still held at the end of the string
    if (string_last) begin
      if (pend_nxt == PEND_PCT) begin
        seq[n] = CH_PCT;  n = n + 3'd1;
        seq[n] = CH_TWO;  n = n + 3'd1;
        seq[n] = CH_FIVE; n = n + 3'd1;
      end else if (pend_nxt == PEND_DIGIT) begin
        seq[n] = CH_PCT;   n = n + 3'd1;
        seq[n] = CH_TWO;   n = n + 3'd1;
        seq[n] = CH_FIVE;  n = n + 3'd1;
        seq[n] = held_nxt; n = n + 3'd1;
      end
      pend_nxt = PEND_NONE;
      held_nxt = '0;
    end
  end

  assign exp.count = n;
  assign exp.last  = string_last;
  assign exp.chars = seq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_NONE;
      held_r <= '0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

/* sv/url_enc_emit.sv */
// url_enc_emit: character shift buffer and output register, one word per cycle
// while out_ready does not stall it; depends on url_enc_pkg
module url_enc_emit
  import url_enc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       take,
  input  expansion_t exp,
  input  logic       out_ready,
  output logic       out_valid,
  output char_t      out_char,
  output logic       run_last,
  output logic       string_end
);

  logic [MAX_OUT-1:0][7:0] buf_r, buf_nxt;
  cnt_t                    rem_r, rem_nxt;
  logic                    last_r, last_nxt;
  logic                    out_valid_r;
  char_t                   out_char_r;
  logic                    run_last_r;
  logic                    string_end_r;
  logic                    load;
  logic                    emit;
  logic                    accept;

  assign load   = !out_valid_r || out_ready;
  assign emit   = load && (rem_r != '0);
  assign take   = (rem_r == '0) || (emit && (rem_r == cnt_t'(1)));
  assign accept = in_valid && take;

  always_comb begin
    buf_nxt  = buf_r;
    rem_nxt  = rem_r;
    last_nxt = last_r;
    if (accept) begin
      buf_nxt  = exp.chars;
      rem_nxt  = exp.count;
      last_nxt = exp.last;
    end else if (emit) begin
      buf_nxt  = {8'h00, buf_r[MAX_OUT-1:1]};
      rem_nxt  = rem_r - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      if (load) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    last_r <= last_nxt;
    if (emit) begin
      out_char_r   <= buf_r[0];
      run_last_r   <= (rem_r == cnt_t'(1));
      string_end_r <= (rem_r == cnt_t'(1)) && last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_char   = out_char_r;
  assign run_last   = run_last_r;
  assign string_end = string_end_r;

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r == '0) |-> take)
    else $error("buffer empty but input not ready");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && string_end_r) |-> run_last_r)
    else $error("string end without run last");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (rem_r == $past(exp.count)))
    else $error("buffer count mismatch after accept");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= cnt_t'(MAX_OUT))
    else $error("buffer count out of range");

endmodule
